// ----- sv/tceb_pkg.sv -----
// ----------------------------------------------------------------------------
// tceb_pkg
// Shared request codes, result codes and the controller/datapath interface
// structs of the timestamp coincidence event builder.
// ----------------------------------------------------------------------------
package tceb_pkg;

  typedef enum logic [1:0] {
    REQ_HIT    = 2'd0,
    REQ_MARK   = 2'd1,
    REQ_BUILD  = 2'd2,
    REQ_OFFSET = 2'd3
  } req_t;

  localparam logic ST_BUILT = 1'b0;
  localparam logic ST_NONE  = 1'b1;

  localparam logic [2:0] CFG_PRE_TRIGGER   = 3'd0;
  localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd1;
  localparam logic [2:0] CFG_SAFE_READS    = 3'd2;
  localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [2:0] CFG_TRIGGER_MASK  = 3'd4;

  typedef struct packed {
    logic latch_req;
    logic use_req_ch;
    logic push_hit;
    logic push_mark;
    logic dec_rc;
    logic load_off;
    logic drop_head;
    logic rd_head;
    logic set_mark;
    logic time_check;
    logic get_load;
    logic earl_init;
    logic earl_upd;
    logic find_init;
    logic find_hit;
    logic find_need;
    logic win_start;
    logic win_end;
    logic buf_wr_hit;
    logic buf_wr_miss;
    logic buf_rd;
    logic out_load_buf;
    logic out_load_fail;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    req_t rq_type;
    logic rq_active;
    logic rq_valid;
    logic cnt_zero;
    logic rd_mark;
    logic grl_lt_earl;
    logic mark_gt_grl;
    logic need_bad;
    logic found;
    logic start_pos;
    logic t_lt_start;
    logic t_lt_end;
    logic mark_gt_trs;
    logic out_busy;
  } sts_t;

endpackage

// ----- sv/tceb_datapath.sv -----
// ----------------------------------------------------------------------------
// tceb_datapath
// Channel FIFOs in one hit store, per-channel read marks, times and offsets,
// trigger search registers, result buffer and the output register.
// ----------------------------------------------------------------------------
module tceb_datapath #(
  parameter int CHANNELS   = 16,
  parameter int FIFO_DEPTH = 256,
  parameter int TIME_BITS  = 48,
  localparam int NW = $clog2(CHANNELS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [1:0]            req_type,
  input  logic [3:0]            channel,
  input  logic [30:0]           hit_value,
  input  logic [TIME_BITS-1:0]  hit_time,
  input  logic signed [31:0]    offset_value,
  input  tceb_pkg::cmd_t        cmd,
  input  logic [NW-1:0]         sel_ch,
  output tceb_pkg::sts_t        sts,
  output logic [NW-1:0]         n_act,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  status,
  output logic [3:0]            out_channel,
  output logic                  in_window,
  output logic [30:0]           out_value,
  output logic signed [TIME_BITS:0] rel_time,
  output logic                  overflow,
  output logic                  last
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW  = $clog2(FIFO_DEPTH);
  localparam int CNW = $clog2(FIFO_DEPTH + 1);
  localparam int SD  = CHANNELS * FIFO_DEPTH;
  localparam int AW  = $clog2(SD);
  localparam int TB  = TIME_BITS;
  localparam int CW  = ((TB > 32) ? TB : 32) + 1;
  localparam int SW  = CW + 1;
  localparam int EWD = 1 + 32 + TB;
  localparam int RW  = 1 + 31 + TB + 1;
  localparam logic [CW-1:0] TSAT = CW'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [CW+1:0] ESAT = (CW + 2)'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [CW:0] RMAX = (CW + 1)'({1'b0, {TB{1'b1}}});
  localparam logic signed [CW:0] RMIN = ~RMAX;

  logic [31:0] pre_trigger;
  logic [31:0] window_length;
  logic [7:0]  safe_reads;
  logic [4:0]  channel_count;
  logic [15:0] trigger_mask;

  tceb_pkg::req_t rq_type;
  logic [3:0]       rq_ch;
  logic [30:0]      rq_val;
  logic [TB-1:0]    rq_time;
  logic signed [31:0] rq_off;

  logic [PW-1:0]        head  [CHANNELS];
  logic [CNW-1:0]       count [CHANNELS];
  logic signed [31:0]   mark  [CHANNELS];
  logic signed [TB:0]   prev  [CHANNELS];
  logic signed [31:0]   offs  [CHANNELS];

  logic signed [31:0] rc;
  logic signed [31:0] grl;
  logic signed [31:0] earliest;
  logic signed [31:0] trig_read;
  logic signed [31:0] need;
  logic [CW-1:0]      trig_time;
  logic               found;
  logic               ovf;
  logic [30:0]        gv;
  logic [CW-1:0]      gt;
  logic signed [CW:0]   wstart;
  logic signed [CW+1:0] wend;

  logic [EWD-1:0] store [SD];
  logic [EWD-1:0] rd;
  logic [RW-1:0]  rbuf [CHANNELS];
  logic [RW-1:0]  rb;

  logic [CHW-1:0]     idx;
  logic [PW-1:0]      cur_head;
  logic [CNW-1:0]     cur_count;
  logic signed [31:0] cur_mark;
  logic signed [31:0] cur_off;
  logic [PW:0]        tail_sum;
  logic [PW-1:0]      tail;
  logic [PW-1:0]      head_inc;
  logic [AW-1:0]      base;
  logic               full;
  logic               mem_we;
  logic [EWD-1:0]     mem_wd;
  logic               rd_mark;
  logic [31:0]        rd_val;
  logic [TB-1:0]      rd_time;
  logic signed [SW-1:0] csum;
  logic [CW-1:0]      corr;
  logic signed [32:0] tr_minus;
  logic [15:0]        trig_bits;
  logic               trig_ok;
  logic signed [CW:0] dlt;
  logic signed [CW:0] rel_c;

  assign n_act = (32'(channel_count) > CHANNELS) ? NW'(CHANNELS) : NW'(channel_count);

  assign idx       = cmd.use_req_ch ? CHW'(rq_ch) : sel_ch[CHW-1:0];
  assign cur_head  = head[idx];
  assign cur_count = count[idx];
  assign cur_mark  = mark[idx];
  assign cur_off   = offs[idx];
  assign full      = (32'(cur_count) == FIFO_DEPTH);
  assign tail_sum  = (PW + 1)'(cur_head) + (PW + 1)'(cur_count);
  assign tail      = (32'(tail_sum) >= FIFO_DEPTH) ? PW'(32'(tail_sum) - FIFO_DEPTH)
                                                   : tail_sum[PW-1:0];
  assign head_inc  = (32'(cur_head) == FIFO_DEPTH - 1) ? '0 : cur_head + PW'(1);
  assign base      = AW'(idx) * AW'(FIFO_DEPTH);

  assign rd_mark = rd[EWD-1];
  assign rd_val  = rd[EWD-2 -: 32];
  assign rd_time = rd[TB-1:0];

  assign mem_we = (cmd.push_hit || cmd.push_mark) && !full;
  assign mem_wd = cmd.push_mark ? {1'b1, rc, {TB{1'b0}}} : {1'b0, 1'b0, rq_val, rq_time};

  always_comb begin
    csum = $signed(SW'(rd_time)) + SW'(cur_off);
    if (csum[SW-1]) begin
      corr = '0;
    end else if (CW >= 64 && csum[CW-1]) begin
      corr = TSAT;
    end else begin
      corr = csum[CW-1:0];
    end
  end

  assign tr_minus  = $signed({trig_read[31], trig_read}) - $signed({25'd0, safe_reads});
  assign trig_bits = trigger_mask >> sel_ch;
  assign trig_ok   = (32'(sel_ch) < 32'd16) && trig_bits[0] && (cur_mark >= trig_read) &&
                     (!found || (gt < trig_time));

  always_comb begin
    dlt = $signed({1'b0, gt}) - $signed({1'b0, trig_time});
    if (dlt > RMAX) begin
      rel_c = RMAX;
    end else if (dlt < RMIN) begin
      rel_c = RMIN;
    end else begin
      rel_c = dlt;
    end
  end

  always_comb begin
    sts.rq_type     = rq_type;
    sts.rq_active   = 32'(rq_ch) < 32'(n_act);
    sts.rq_valid    = 32'(rq_ch) < CHANNELS;
    sts.cnt_zero    = (cur_count == '0);
    sts.rd_mark     = rd_mark;
    sts.grl_lt_earl = grl < earliest;
    sts.mark_gt_grl = cur_mark > grl;
    sts.need_bad    = $signed({need[31], need}) > tr_minus;
    sts.found       = found;
    sts.start_pos   = wstart > 0;
    sts.t_lt_start  = $signed({1'b0, gt}) < wstart;
    sts.t_lt_end    = $signed({2'b0, gt}) < wend;
    sts.mark_gt_trs = $signed({cur_mark[31], cur_mark}) > tr_minus;
    sts.out_busy    = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[base + AW'(tail)] <= mem_wd;
    end
    if (cmd.rd_head) begin
      rd <= store[base + AW'(cur_head)];
    end
    if (cmd.buf_wr_hit) begin
      rbuf[idx] <= {1'b1, gv, rel_c[TB:0]};
    end else if (cmd.buf_wr_miss) begin
      rbuf[idx] <= '0;
    end
    if (cmd.buf_rd) begin
      rb <= rbuf[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      rq_type <= tceb_pkg::req_t'(req_type);
      rq_ch   <= channel;
      rq_val  <= hit_value;
      rq_time <= hit_time;
      rq_off  <= offset_value;
    end
    if (cmd.get_load) begin
      gv <= rd_val[30:0];
      gt <= corr;
    end
    if (cmd.earl_init) begin
      earliest <= rc;
    end else if (cmd.earl_upd && (cur_mark > earliest)) begin
      earliest <= cur_mark;
    end
    if (cmd.find_init) begin
      trig_read <= rc;
      trig_time <= '0;
      need      <= rc;
    end else begin
      if (cmd.find_hit && trig_ok) begin
        trig_read <= cur_mark;
        trig_time <= gt;
      end
      if (cmd.find_need && (cur_mark > need)) begin
        need <= cur_mark;
      end
    end
    if (cmd.win_start) begin
      wstart <= $signed({1'b0, trig_time}) - $signed((CW + 1)'(pre_trigger));
    end
    if (cmd.win_end) begin
      if (CW >= 64 && ((CW + 2)'(wstart) + $signed((CW + 2)'(window_length))) > ESAT) begin
        wend <= ESAT;
      end else begin
        wend <= (CW + 2)'(wstart) + $signed((CW + 2)'(window_length));
      end
    end
    if (cmd.out_load_buf) begin
      status      <= tceb_pkg::ST_BUILT;
      out_channel <= 4'(sel_ch);
      in_window   <= rb[RW-1];
      out_value   <= rb[RW-2 -: 31];
      rel_time    <= rb[TB:0];
      overflow    <= ovf;
      last        <= cmd.out_last;
    end else if (cmd.out_load_fail) begin
      status      <= tceb_pkg::ST_NONE;
      out_channel <= '0;
      in_window   <= 1'b0;
      out_value   <= '0;
      rel_time    <= '0;
      overflow    <= ovf;
      last        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_trigger   <= '0;
      window_length <= 32'd10;
      safe_reads    <= 8'd4;
      channel_count <= '0;
      trigger_mask  <= 16'hFFFF;
      rc            <= '0;
      grl           <= '0;
      found         <= 1'b0;
      ovf           <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
        mark[i]  <= '0;
        prev[i]  <= '1;
        offs[i]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tceb_pkg::CFG_PRE_TRIGGER:   pre_trigger   <= cfg_data;
          tceb_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data;
          tceb_pkg::CFG_SAFE_READS:    safe_reads    <= cfg_data[7:0];
          tceb_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
          tceb_pkg::CFG_TRIGGER_MASK:  trigger_mask  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if ((cmd.push_hit || cmd.push_mark) && full) begin
        ovf <= 1'b1;
      end
      if (mem_we) begin
        count[idx] <= cur_count + CNW'(1);
      end
      if (cmd.drop_head) begin
        head[idx]  <= head_inc;
        count[idx] <= cur_count - CNW'(1);
      end
      if (cmd.set_mark) begin
        mark[idx] <= rd_val;
      end
      if (cmd.time_check) begin
        if (prev[idx] > $signed({1'b0, rd_time})) begin
          prev[idx] <= '0;
          grl       <= cur_mark + $signed({24'd0, safe_reads});
        end else begin
          prev[idx] <= $signed({1'b0, rd_time});
        end
      end
      if (cmd.load_off) begin
        offs[idx] <= rq_off;
      end
      if (cmd.dec_rc) begin
        rc <= rc - 32'sd1;
      end
      if (cmd.find_init) begin
        found <= 1'b0;
      end else if (cmd.find_hit && trig_ok) begin
        found <= 1'b1;
      end
      if (cmd.out_load_buf || cmd.out_load_fail) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/tceb_ctrl.sv -----
// ----------------------------------------------------------------------------
// tceb_ctrl
// Sequencer of the event builder: request dispatch, marker broadcast, build
// phases, and the shared pop and fetch routines on the channel FIFOs.
// ----------------------------------------------------------------------------
module tceb_ctrl #(
  parameter int CHANNELS = 16,
  localparam int NW = $clog2(CHANNELS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output tceb_pkg::cmd_t cmd,
  output logic [NW-1:0]  sel_ch,
  input  tceb_pkg::sts_t sts,
  input  logic [NW-1:0]  n_act
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MPUSH, S_A1, S_A2, S_A3, S_FINIT, S_B1, S_B2, S_B3, S_B4,
    S_PTG2, S_C1, S_C2, S_C3, S_C4, S_EINIT, S_E1, S_E2, S_E3, S_EM0, S_EM1,
    S_FAIL, S_P0, S_P1, S_P2, S_G0, S_G1, S_G2
  } state_t;

  state_t        state, state_next;
  state_t        pop_ret, pop_ret_next;
  state_t        get_ret, get_ret_next;
  logic [NW-1:0] c, c_next;
  logic          ok, ok_next;
  logic          second, second_next;
  logic          at_end;
  logic          last_c;

  assign sel_ch   = c;
  assign in_ready = (state == S_IDLE);
  assign at_end   = (c == n_act);
  assign last_c   = ((NW + 1)'(c) + (NW + 1)'(1)) == (NW + 1)'(n_act);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    pop_ret_next = pop_ret;
    get_ret_next = get_ret;
    c_next       = c;
    ok_next      = ok;
    second_next  = second;
    unique case (state)
      S_IDLE: begin
        cmd.latch_req = in_valid;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        cmd.use_req_ch = 1'b1;
        state_next     = S_IDLE;
        unique case (sts.rq_type)
          tceb_pkg::REQ_HIT:    cmd.push_hit = sts.rq_active;
          tceb_pkg::REQ_OFFSET: cmd.load_off = sts.rq_valid;
          tceb_pkg::REQ_MARK: begin
            cmd.dec_rc = 1'b1;
            c_next     = '0;
            state_next = S_MPUSH;
          end
          tceb_pkg::REQ_BUILD: begin
            if (n_act == '0) begin
              state_next = S_FAIL;
            end else begin
              cmd.earl_init = 1'b1;
              c_next        = '0;
              second_next   = 1'b0;
              state_next    = S_A1;
            end
          end
        endcase
      end
      S_MPUSH: begin
        if (at_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.push_mark = 1'b1;
          c_next        = c + NW'(1);
        end
      end
      S_A1: begin
        if (at_end) begin
          if (sts.grl_lt_earl) begin
            c_next     = '0;
            state_next = S_A2;
          end else begin
            state_next = second ? S_EINIT : S_FINIT;
          end
        end else begin
          cmd.earl_upd = 1'b1;
          c_next       = c + NW'(1);
        end
      end
      S_A2: begin
        if (at_end) begin
          state_next = second ? S_EINIT : S_FINIT;
        end else if (sts.mark_gt_grl) begin
          pop_ret_next = S_A3;
          state_next   = S_P0;
        end else begin
          c_next = c + NW'(1);
        end
      end
      S_A3: state_next = ok ? S_A2 : S_FAIL;
      S_FINIT: begin
        cmd.find_init = 1'b1;
        c_next        = '0;
        state_next    = S_B1;
      end
      S_B1: begin
        if (at_end) begin
          state_next = S_B3;
        end else begin
          get_ret_next = S_B2;
          state_next   = S_G0;
        end
      end
      S_B2: begin
        cmd.find_hit  = ok;
        cmd.find_need = !ok;
        c_next        = c + NW'(1);
        state_next    = S_B1;
      end
      S_B3: begin
        if (sts.need_bad || !sts.found) begin
          state_next = S_FAIL;
        end else begin
          cmd.win_start = 1'b1;
          state_next    = S_B4;
        end
      end
      S_B4: begin
        cmd.win_end = 1'b1;
        c_next      = '0;
        state_next  = sts.start_pos ? S_C1 : S_PTG2;
      end
      S_PTG2: begin
        cmd.earl_init = 1'b1;
        c_next        = '0;
        second_next   = 1'b1;
        state_next    = S_A1;
      end
      S_C1: begin
        if (at_end) begin
          state_next = S_PTG2;
        end else begin
          get_ret_next = S_C2;
          state_next   = S_G0;
        end
      end
      S_C2: begin
        if (!ok) begin
          state_next = S_C4;
        end else if (sts.t_lt_start) begin
          pop_ret_next = S_C3;
          state_next   = S_P0;
        end else begin
          c_next     = c + NW'(1);
          state_next = S_C1;
        end
      end
      S_C3: begin
        if (ok) begin
          get_ret_next = S_C2;
          state_next   = S_G0;
        end else begin
          state_next = S_C4;
        end
      end
      S_C4: begin
        if (sts.mark_gt_trs) begin
          state_next = S_FAIL;
        end else begin
          c_next     = c + NW'(1);
          state_next = S_C1;
        end
      end
      S_EINIT: begin
        c_next     = '0;
        state_next = S_E1;
      end
      S_E1: begin
        if (at_end) begin
          c_next     = '0;
          state_next = S_EM0;
        end else begin
          get_ret_next = S_E2;
          state_next   = S_G0;
        end
      end
      S_E2: begin
        if (!ok) begin
          state_next = S_FAIL;
        end else if (sts.t_lt_end) begin
          cmd.buf_wr_hit = 1'b1;
          pop_ret_next   = S_E3;
          state_next     = S_P0;
        end else begin
          cmd.buf_wr_miss = 1'b1;
          c_next          = c + NW'(1);
          state_next      = S_E1;
        end
      end
      S_E3: begin
        c_next     = c + NW'(1);
        state_next = S_E1;
      end
      S_EM0: begin
        cmd.buf_rd = 1'b1;
        state_next = S_EM1;
      end
      S_EM1: begin
        if (!sts.out_busy) begin
          cmd.out_load_buf = 1'b1;
          cmd.out_last     = last_c;
          if (last_c) begin
            state_next = S_IDLE;
          end else begin
            c_next     = c + NW'(1);
            state_next = S_EM0;
          end
        end
      end
      S_FAIL: begin
        if (!sts.out_busy) begin
          cmd.out_load_fail = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_P0: begin
        if (sts.cnt_zero) begin
          ok_next    = 1'b0;
          state_next = pop_ret;
        end else begin
          cmd.drop_head = 1'b1;
          state_next    = S_P1;
        end
      end
      S_P1: begin
        if (sts.cnt_zero) begin
          ok_next    = 1'b0;
          state_next = pop_ret;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = S_P2;
        end
      end
      S_P2: begin
        if (sts.rd_mark) begin
          cmd.set_mark  = 1'b1;
          cmd.drop_head = 1'b1;
          state_next    = S_P1;
        end else begin
          cmd.time_check = 1'b1;
          ok_next        = 1'b1;
          state_next     = pop_ret;
        end
      end
      S_G0: begin
        if (sts.cnt_zero) begin
          ok_next    = 1'b0;
          state_next = get_ret;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = S_G1;
        end
      end
      S_G1: begin
        if (sts.rd_mark) begin
          pop_ret_next = S_G2;
          state_next   = S_P0;
        end else begin
          cmd.get_load = 1'b1;
          ok_next      = 1'b1;
          state_next   = get_ret;
        end
      end
      S_G2: begin
        cmd.get_load = ok;
        state_next   = get_ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pop_ret <= S_IDLE;
      get_ret <= S_IDLE;
      c       <= '0;
      ok      <= 1'b0;
      second  <= 1'b0;
    end else begin
      state   <= state_next;
      pop_ret <= pop_ret_next;
      get_ret <= get_ret_next;
      c       <= c_next;
      ok      <= ok_next;
      second  <= second_next;
    end
  end

endmodule

// ----- sv/timestamp_coincidence_event_builder_unit.sv -----
// ----------------------------------------------------------------------------
// timestamp_coincidence_event_builder_unit
// Multi-channel hit buffering and coincidence event building.
// ----------------------------------------------------------------------------
// The input channel takes one request per beat: a hit, an end of read block,
// a build request or a channel time offset load. The configuration channel
// writes one register per beat and is always ready; write it only while idle.
// Only a build request gives results: one beat per active channel with last
// on the final one, or a single beat with status set when no event is built.
// An end of read block makes one hit store write per active channel, in turn.
// In a build, every head fetch is a registered read of the single-port hit
// store, and the channels are walked one at a time. Each result beat is read
// from the result buffer and then loaded into the output register.
// The output register frees the input side: a new request is taken while the
// last result still waits. A stalled receiver holds the sequencer before the
// next result beat. Reset empties all FIFOs and clears the read counters and
// the overflow flag; the hit store itself needs no clearing pass.
// ----------------------------------------------------------------------------
module timestamp_coincidence_event_builder_unit #(
  parameter int CHANNELS   = 16,
  parameter int FIFO_DEPTH = 256,
  parameter int TIME_BITS  = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [3:0]                channel,
  input  logic [30:0]               hit_value,
  input  logic [TIME_BITS-1:0]      hit_time,
  input  logic signed [31:0]        offset_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      status,
  output logic [3:0]                out_channel,
  output logic                      in_window,
  output logic [30:0]               out_value,
  output logic signed [TIME_BITS:0] rel_time,
  output logic                      overflow,
  output logic                      last
);

  localparam int NW = $clog2(CHANNELS + 1);

  tceb_pkg::cmd_t cmd;
  tceb_pkg::sts_t sts;
  logic [NW-1:0]  sel_ch;
  logic [NW-1:0]  n_act;

  assign cfg_ready = 1'b1;

  tceb_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sel_ch   (sel_ch),
    .sts      (sts),
    .n_act    (n_act)
  );

  tceb_datapath #(
    .CHANNELS  (CHANNELS),
    .FIFO_DEPTH(FIFO_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .channel      (channel),
    .hit_value    (hit_value),
    .hit_time     (hit_time),
    .offset_value (offset_value),
    .cmd          (cmd),
    .sel_ch       (sel_ch),
    .sts          (sts),
    .n_act        (n_act),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .out_channel  (out_channel),
    .in_window    (in_window),
    .out_value    (out_value),
    .rel_time     (rel_time),
    .overflow     (overflow),
    .last         (last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is still dispatched");

  a_latch_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_req |-> in_valid && in_ready)
    else $error("request latched without an input beat");

  a_no_event_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tceb_pkg::ST_NONE) |->
      last && !in_window && (out_value == '0) && (rel_time == '0))
    else $error("no-event result is not a single empty beat");

endmodule
